// ----- rtl/core/blpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Backlight duty package
// Shared widths, register indexes, reset values and types for the backlight
// luminance to PWM duty block.
// ----------------------------------------------------------------------------
package blpd_pkg;

   localparam int DUTY_BITS_DEF  = 10;
   localparam int LUM_BITS_DEF   = 10;

   localparam int COEF_BITS      = 32;
   localparam int BMAX_BITS      = 16;
   localparam int CTL_BITS       = 17;
   localparam int CTL_ENABLE_BIT = 16;
   localparam int PERIOD_BITS    = 10;
   localparam int SCALE_BITS     = PERIOD_BITS + 1;
   localparam int FRAC_BITS      = 28;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SCALE_BITS-1:0] SCALE_DISABLED = SCALE_BITS'(512);

   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_COEF_A        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_COEF_B        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_COEF_C        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BOT_COEF_A        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BOT_COEF_B        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BOT_COEF_C        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BRIGHTNESS_MAX    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAP_BOTTOM_ENABLE = 3'd7;

   localparam logic signed [COEF_BITS-1:0] RST_TOP_COEF_A = 32'sd112251;
   localparam logic signed [COEF_BITS-1:0] RST_TOP_COEF_B = 32'sd178689430;
   localparam logic signed [COEF_BITS-1:0] RST_TOP_COEF_C = 32'sd16370949;
   localparam logic signed [COEF_BITS-1:0] RST_BOT_COEF_A = 32'sd299678;
   localparam logic signed [COEF_BITS-1:0] RST_BOT_COEF_B = 32'sd379599947;
   localparam logic signed [COEF_BITS-1:0] RST_BOT_COEF_C = 32'sd19270469;
   localparam logic [BMAX_BITS-1:0]        RST_BMAX       = 16'd512;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] a;
      logic signed [COEF_BITS-1:0] b;
      logic signed [COEF_BITS-1:0] c;
   } coef_type;

   // Width of the scaled value that enters the divider.
   function automatic int div_bits(input int lum_bits);
      return 2 * lum_bits + 17;
   endfunction

endpackage

// ----- rtl/core/blpd_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; only the low quotient bits are kept.
// ----------------------------------------------------------------------------
module blpd_div #(
   parameter int MW = 37,
   parameter int QW = 10
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [MW-1:0]                  dividend,
   input  logic [blpd_pkg::BMAX_BITS-1:0] divisor,
   output logic [QW-1:0]                  quotient
);
   import blpd_pkg::*;

   logic [BMAX_BITS-1:0] rem_ff [MW-1];
   logic [MW-1:0]        m_ff   [MW-1];
   logic [QW-1:0]        q_ff   [MW];

   genvar k;
   generate
      for (k = 0; k < MW; k++) begin : g_stage
         logic [BMAX_BITS-1:0] rem_prev;
         logic [MW-1:0]        m_prev;
         logic [QW-1:0]        q_prev;
         logic [BMAX_BITS:0]   trial;
         logic                 ge;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign m_prev   = dividend;
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign m_prev   = m_ff[k-1];
            assign q_prev   = q_ff[k-1];
         end

         assign trial = {rem_prev, m_prev[MW-1]};
         assign ge    = trial >= {1'b0, divisor};

         always_ff @(posedge clock) begin
            if (enable) begin
               q_ff[k] <= {q_prev[QW-2:0], ge};
            end
         end

         if (k < MW - 1) begin : g_carry
            logic [BMAX_BITS-1:0] rem_in;
            logic [BMAX_BITS:0]   diff;
            assign diff   = trial - {1'b0, divisor};
            assign rem_in = ge ? diff[BMAX_BITS-1:0] : trial[BMAX_BITS-1:0];
            always_ff @(posedge clock) begin
               if (enable) begin
                  rem_ff[k] <= rem_in;
                  m_ff[k]   <= {m_prev[MW-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign quotient = q_ff[MW-1];

endmodule

// ----- rtl/core/blpd_lane.sv -----
// ----------------------------------------------------------------------------
// Panel duty lane
// Evaluates the panel quadratic, scales it by the PWM period and divides by
// the full-scale brightness with rounding.
// ----------------------------------------------------------------------------
module blpd_lane #(
   parameter int DUTY_BITS      = blpd_pkg::DUTY_BITS_DEF,
   parameter int LUMINANCE_BITS = blpd_pkg::LUM_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [LUMINANCE_BITS-1:0]      lum,
   input  logic [blpd_pkg::CTL_BITS-1:0]  ctl,
   input  blpd_pkg::coef_type             coef,
   input  logic [blpd_pkg::BMAX_BITS-1:0] bmax,
   output logic [DUTY_BITS-1:0]           duty
);
   import blpd_pkg::*;

   localparam int XW    = LUMINANCE_BITS + 1;
   localparam int PW    = COEF_BITS + XW;
   localparam int YW    = COEF_BITS + 2 * XW;
   localparam int MAG_W = YW - 1;
   localparam int NW    = MAG_W + SCALE_BITS + 1;
   localparam int MW    = div_bits(LUMINANCE_BITS);

   logic signed [XW-1:0]        x_in;
   logic [SCALE_BITS-1:0]       scale_in;
   logic signed [PW-1:0]        ax1_in;
   logic signed [PW-1:0]        bx1_in;

   logic signed [XW-1:0]        x1_ff;
   logic signed [PW-1:0]        ax1_ff;
   logic signed [PW-1:0]        bx1_ff;
   logic signed [COEF_BITS-1:0] c1_ff;
   logic [SCALE_BITS-1:0]       sc1_ff;

   logic signed [YW-1:0]        y2_in;
   logic signed [YW-1:0]        y2_ff;
   logic [SCALE_BITS-1:0]       sc2_ff;

   logic                        pos;
   logic [NW-1:0]               n3;
   logic [MW-1:0]               m3_in;
   logic [MW-1:0]               m3_ff;

   assign x_in     = $signed({1'b0, lum});
   assign scale_in = ctl[CTL_ENABLE_BIT] ?
                     SCALE_BITS'(ctl[PERIOD_BITS-1:0]) + SCALE_BITS'(1) : SCALE_DISABLED;
   assign ax1_in   = PW'(coef.a) * PW'(x_in);
   assign bx1_in   = PW'(coef.b) * PW'(x_in);

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff  <= x_in;
         ax1_ff <= ax1_in;
         bx1_ff <= bx1_in;
         c1_ff  <= coef.c;
         sc1_ff <= scale_in;
      end
   end

   assign y2_in = YW'(ax1_ff) * YW'(x1_ff) + YW'(bx1_ff) + YW'(c1_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         y2_ff  <= y2_in;
         sc2_ff <= sc1_ff;
      end
   end

   // A polynomial at or below zero enters the divider as zero.
   assign pos   = !y2_ff[YW-1] && (y2_ff != '0);
   assign n3    = NW'(y2_ff[MAG_W-1:0]) * NW'(sc2_ff) + (NW'(bmax) << (FRAC_BITS - 1));
   assign m3_in = pos ? n3[NW-1:FRAC_BITS] : '0;

   always_ff @(posedge clock) begin
      if (enable) begin
         m3_ff <= m3_in;
      end
   end

   blpd_div #(
      .MW (MW),
      .QW (DUTY_BITS)
   ) u_div (
      .clock    (clock),
      .enable   (enable),
      .dividend (m3_ff),
      .divisor  (bmax),
      .quotient (duty)
   );

endmodule

// ----- rtl/core/blpd_merge.sv -----
// ----------------------------------------------------------------------------
// Duty merge stage
// Joins the two lane results, applies the optional bottom cap and holds the
// outgoing word.
// ----------------------------------------------------------------------------
module blpd_merge #(
   parameter int DUTY_BITS = blpd_pkg::DUTY_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic                 cap_en,
   input  logic [DUTY_BITS-1:0] duty_top,
   input  logic [DUTY_BITS-1:0] duty_bot,
   output logic [DUTY_BITS-1:0] duty_top_q,
   output logic [DUTY_BITS-1:0] duty_bot_q,
   output logic                 capped_q
);
   logic                 capped_in;
   logic [DUTY_BITS-1:0] duty_bot_in;
   logic [DUTY_BITS-1:0] duty_top_ff;
   logic [DUTY_BITS-1:0] duty_bot_ff;
   logic                 capped_ff;

   assign capped_in   = cap_en && (duty_bot > duty_top);
   assign duty_bot_in = capped_in ? duty_top : duty_bot;

   always_ff @(posedge clock) begin
      if (enable) begin
         duty_top_ff <= duty_top;
         duty_bot_ff <= duty_bot_in;
         capped_ff   <= capped_in;
      end
   end

   assign duty_top_q = duty_top_ff;
   assign duty_bot_q = duty_bot_ff;
   assign capped_q   = capped_ff;

endmodule

// ----- rtl/core/backlight_luminance_to_pwm_duty.sv -----
// ----------------------------------------------------------------------------
// Backlight luminance to PWM duty
// Converts top and bottom luminance targets to PWM duty values.
// ----------------------------------------------------------------------------
// The block accepts one word per clock while the output is not stalled and
// returns one word per accepted word, in order. Most of the pipeline is the
// pipelined divider, which resolves one quotient bit per stage. A one-word
// input skid keeps req_tready registered, so a new word is taken while a
// finished one waits on the output. Configuration writes are taken every
// cycle and must only be made while no word is in flight.
module backlight_luminance_to_pwm_duty #(
   parameter int  DUTY_BITS      = blpd_pkg::DUTY_BITS_DEF,
   parameter int  LUMINANCE_BITS = blpd_pkg::LUM_BITS_DEF,
   localparam int REQ_W = ((2 * LUMINANCE_BITS + 2 * blpd_pkg::CTL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * DUTY_BITS + 1 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lum_top, lum_bot, pwm_ctl_top, pwm_ctl_bot, zero fill
   input  logic [REQ_W-1:0]                    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // duty_top, duty_bot, bot_was_capped, zero fill
   output logic [RSP_W-1:0]                    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [blpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [blpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import blpd_pkg::*;

   localparam int FIELD_W = 2 * LUMINANCE_BITS + 2 * CTL_BITS;
   localparam int LAT     = div_bits(LUMINANCE_BITS) + 4;
   localparam int PAD_W   = RSP_W - 2 * DUTY_BITS - 1;

   coef_type             coef_top_ff;
   coef_type             coef_bot_ff;
   logic [BMAX_BITS-1:0] bmax_ff;
   logic                 cap_en_ff;
   logic [BMAX_BITS-1:0] bmax_eff;

   logic                 skid_v_ff;
   logic                 skid_v_in;
   logic [FIELD_W-1:0]   skid_data_ff;
   logic [FIELD_W-1:0]   src_data;
   logic                 src_v;
   logic                 req_fire;
   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;

   logic [DUTY_BITS-1:0] lane_duty_top;
   logic [DUTY_BITS-1:0] lane_duty_bot;
   logic [DUTY_BITS-1:0] duty_top_q;
   logic [DUTY_BITS-1:0] duty_bot_q;
   logic                 capped_q;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '{a: RST_TOP_COEF_A, b: RST_TOP_COEF_B, c: RST_TOP_COEF_C};
         coef_bot_ff <= '{a: RST_BOT_COEF_A, b: RST_BOT_COEF_B, c: RST_BOT_COEF_C};
         bmax_ff     <= RST_BMAX;
         cap_en_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TOP_COEF_A:        coef_top_ff.a <= $signed(csr_wdata);
            REG_TOP_COEF_B:        coef_top_ff.b <= $signed(csr_wdata);
            REG_TOP_COEF_C:        coef_top_ff.c <= $signed(csr_wdata);
            REG_BOT_COEF_A:        coef_bot_ff.a <= $signed(csr_wdata);
            REG_BOT_COEF_B:        coef_bot_ff.b <= $signed(csr_wdata);
            REG_BOT_COEF_C:        coef_bot_ff.c <= $signed(csr_wdata);
            REG_BRIGHTNESS_MAX:    bmax_ff       <= csr_wdata[BMAX_BITS-1:0];
            REG_CAP_BOTTOM_ENABLE: cap_en_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A full-scale brightness of zero is treated as one.
   assign bmax_eff = (bmax_ff == '0) ? BMAX_BITS'(1) : bmax_ff;

   assign req_tready = !skid_v_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign src_data   = skid_v_ff ? skid_data_ff : req_tdata[FIELD_W-1:0];
   assign src_v      = skid_v_ff || req_fire;

   always_comb begin
      skid_v_in = skid_v_ff;
      if (adv) begin
         skid_v_in = 1'b0;
      end else if (req_fire) begin
         skid_v_in = 1'b1;
      end
   end

   assign vld_in = adv ? {vld_ff[LAT-2:0], src_v} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         vld_ff    <= '0;
      end else begin
         skid_v_ff <= skid_v_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !adv) begin
         skid_data_ff <= req_tdata[FIELD_W-1:0];
      end
   end

   blpd_lane #(
      .DUTY_BITS      (DUTY_BITS),
      .LUMINANCE_BITS (LUMINANCE_BITS)
   ) u_lane_top (
      .clock  (clock),
      .enable (adv),
      .lum    (src_data[LUMINANCE_BITS-1:0]),
      .ctl    (src_data[2*LUMINANCE_BITS+CTL_BITS-1:2*LUMINANCE_BITS]),
      .coef   (coef_top_ff),
      .bmax   (bmax_eff),
      .duty   (lane_duty_top)
   );

   blpd_lane #(
      .DUTY_BITS      (DUTY_BITS),
      .LUMINANCE_BITS (LUMINANCE_BITS)
   ) u_lane_bot (
      .clock  (clock),
      .enable (adv),
      .lum    (src_data[2*LUMINANCE_BITS-1:LUMINANCE_BITS]),
      .ctl    (src_data[FIELD_W-1:2*LUMINANCE_BITS+CTL_BITS]),
      .coef   (coef_bot_ff),
      .bmax   (bmax_eff),
      .duty   (lane_duty_bot)
   );

   blpd_merge #(
      .DUTY_BITS (DUTY_BITS)
   ) u_merge (
      .clock      (clock),
      .enable     (adv),
      .cap_en     (cap_en_ff),
      .duty_top   (lane_duty_top),
      .duty_bot   (lane_duty_bot),
      .duty_top_q (duty_top_q),
      .duty_bot_q (duty_bot_q),
      .capped_q   (capped_q)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {PAD_W'(0), capped_q, duty_bot_q, duty_top_q};

`ifndef SYNTHESIS
   a_cap_equalizes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && capped_q |-> duty_bot_q == duty_top_q)
      else $error("capped bottom duty differs from top duty");

   a_stall_fills_skid : assert property (@(posedge clock) disable iff (reset)
      req_fire && !adv |=> skid_v_ff)
      else $error("word accepted during stall was not held in skid");

   a_skid_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> vld_ff[LAT-1])
      else $error("skid holds a word while the output stage is empty");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Backlight luminance to PWM duty testbench
// Drives luminance and PWM control words into the block under a series of
// coefficient, brightness and cap settings. It predicts both panel duties
// for every accepted word and compares each returned word against the oldest
// prediction. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blpd_pkg::*;

   localparam int LUM_BITS       = LUM_BITS_DEF;
   localparam int DUTY_BITS      = DUTY_BITS_DEF;
   localparam int REQ_W          = ((2 * LUM_BITS + 2 * CTL_BITS + 7) / 8) * 8;
   localparam int RSP_W          = ((2 * DUTY_BITS + 1 + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [CTL_BITS-1:0] ctl_bot;
      logic [CTL_BITS-1:0] ctl_top;
      logic [LUM_BITS-1:0] lum_bot;
      logic [LUM_BITS-1:0] lum_top;
   } lum_request_type;

   typedef struct packed {
      logic                 capped;
      logic [DUTY_BITS-1:0] bot;
      logic [DUTY_BITS-1:0] top;
   } duty_result_type;

   class duty_scoreboard;
      coef_type             top_coef;
      coef_type             bot_coef;
      logic [BMAX_BITS-1:0] bmax;
      logic                 cap_enable;
      duty_result_type      expected_duties[$];
      int                   result_count;
      int                   mismatch_count;

      function new();
         top_coef       = '{RST_TOP_COEF_A, RST_TOP_COEF_B, RST_TOP_COEF_C};
         bot_coef       = '{RST_BOT_COEF_A, RST_BOT_COEF_B, RST_BOT_COEF_C};
         bmax           = RST_BMAX;
         cap_enable     = 1'b0;
         result_count   = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            REG_TOP_COEF_A:        top_coef.a = data;
            REG_TOP_COEF_B:        top_coef.b = data;
            REG_TOP_COEF_C:        top_coef.c = data;
            REG_BOT_COEF_A:        bot_coef.a = data;
            REG_BOT_COEF_B:        bot_coef.b = data;
            REG_BOT_COEF_C:        bot_coef.c = data;
            REG_BRIGHTNESS_MAX:    bmax = data[BMAX_BITS-1:0];
            REG_CAP_BOTTOM_ENABLE: cap_enable = data[0];
            default: ;
         endcase
      endfunction

      // The rounded quotient is floor((2*y*scale + bmax*2^28) / (bmax*2^29)).
      function logic [DUTY_BITS-1:0] panel_duty(logic [LUM_BITS-1:0] lum, coef_type k,
                                                logic [CTL_BITS-1:0] ctl);
         logic signed [63:0] x;
         logic signed [63:0] y;
         logic [10:0]        scale;
         logic [16:0]        bm;
         logic [95:0]        num;
         logic [95:0]        den;
         logic [95:0]        quo;
         x = 64'(lum);
         y = 64'(k.a) * x * x + 64'(k.b) * x + 64'(k.c);
         if (y <= 0) return '0;
         scale = ctl[CTL_ENABLE_BIT] ? 11'(ctl[PERIOD_BITS-1:0]) + 11'd1 : 11'd512;
         bm    = (bmax == '0) ? 17'd1 : 17'(bmax);
         num   = (96'(y) << 1) * 96'(scale) + (96'(bm) << FRAC_BITS);
         den   = 96'(bm) << (FRAC_BITS + 1);
         quo   = num / den;
         return quo[DUTY_BITS-1:0];
      endfunction

      function void note_request(lum_request_type r);
         duty_result_type d;
         d.top    = panel_duty(r.lum_top, top_coef, r.ctl_top);
         d.bot    = panel_duty(r.lum_bot, bot_coef, r.ctl_bot);
         d.capped = 1'b0;
         if (cap_enable && d.bot > d.top) begin
            d.bot    = d.top;
            d.capped = 1'b1;
         end
         expected_duties.push_back(d);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatch_count++;
      endtask

      task check_response(logic [RSP_W-1:0] word);
         duty_result_type got;
         duty_result_type want;
         got = word[$bits(duty_result_type)-1:0];
         if (expected_duties.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing outstanding",
                                      result_count));
         end else begin
            want = expected_duties.pop_front();
            if (got.top !== want.top)
               report_mismatch($sformatf("word %0d duty_top got %0d expected %0d",
                                         result_count, got.top, want.top));
            if (got.bot !== want.bot)
               report_mismatch($sformatf("word %0d duty_bot got %0d expected %0d",
                                         result_count, got.bot, want.bot));
            if (got.capped !== want.capped)
               report_mismatch($sformatf("word %0d bot_was_capped got %0b expected %0b",
                                         result_count, got.capped, want.capped));
         end
         result_count++;
      endtask
   endclass

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   duty_scoreboard duties = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   backlight_luminance_to_pwm_duty dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) duties.check_response(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic lum_request_type make_request(logic [LUM_BITS-1:0] lt,
                                                    logic [LUM_BITS-1:0] lb,
                                                    logic [CTL_BITS-1:0] ct,
                                                    logic [CTL_BITS-1:0] cb);
      lum_request_type r;
      r.lum_top = lt;
      r.lum_bot = lb;
      r.ctl_top = ct;
      r.ctl_bot = cb;
      return r;
   endfunction

   function automatic coef_type random_coefs(int style, coef_type base);
      coef_type k;
      case (style)
         0: begin
            k.a = base.a + 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
            k.b = base.b + 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
            k.c = base.c + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
         end
         1: begin
            k.a = $urandom();
            k.b = $urandom();
            k.c = $urandom();
         end
         default: begin
            k.a = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            k.b = 32'($urandom_range(0, 1 << 30)) - 32'(1 << 29);
            k.c = 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
         end
      endcase
      return k;
   endfunction

   task automatic send_request(lum_request_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(r);
      do @(posedge clock); while (!req_tready);
      duties.note_request(r);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic run_phase(int count);
      repeat (count) begin
         send_request(make_request(LUM_BITS'($urandom()), LUM_BITS'($urandom()),
                                   CTL_BITS'($urandom()), CTL_BITS'($urandom())));
         sender_gap();
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (duties.expected_duties.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      duties.write_register(index, data);
   endtask

   task automatic load_settings(coef_type top, coef_type bot, logic [31:0] bmax_word,
                                logic [31:0] cap_word);
      wait_for_results();
      write_register(REG_TOP_COEF_A, top.a);
      write_register(REG_TOP_COEF_B, top.b);
      write_register(REG_TOP_COEF_C, top.c);
      write_register(REG_BOT_COEF_A, bot.a);
      write_register(REG_BOT_COEF_B, bot.b);
      write_register(REG_BOT_COEF_C, bot.c);
      write_register(REG_BRIGHTNESS_MAX, bmax_word);
      write_register(REG_CAP_BOTTOM_ENABLE, cap_word);
      csr_valid <= 1'b0;
   endtask

   initial begin
      coef_type             top;
      coef_type             bot;
      logic [BMAX_BITS-1:0] bmax_val;
      int                   idle_modes[4][2];
      idle_modes = '{'{0, 0}, '{77, 0}, '{0, 77}, '{8, 8}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(10'd0, 10'd0, 17'h00000, 17'h00000));
      send_request(make_request(10'd1023, 10'd1023, 17'h103FF, 17'h103FF));
      send_request(make_request(10'd1023, 10'd1023, 17'h10000, 17'h10000));
      send_request(make_request(10'd1023, 10'd1023, 17'h0FFFF, 17'h0FFFF));
      send_request(make_request(10'd512, 10'd300, 17'h1FFFF, 17'h103FF));
      send_request(make_request(10'd1, 10'd1022, 17'h10200, 17'h00000));
      send_request(make_request(10'd700, 10'd1023, 17'h10100, 17'h1FC00));

      top = '{32'h8000_0000, 32'd0, 32'd0};
      bot = '{RST_BOT_COEF_A, RST_BOT_COEF_B, RST_BOT_COEF_C};
      load_settings(top, bot, 32'hFFFF_0000, 32'h8000_0001);
      send_request(make_request(10'd0, 10'd0, 17'h103FF, 17'h103FF));
      send_request(make_request(10'd1, 10'd5, 17'h00000, 17'h10000));
      send_request(make_request(10'd1023, 10'd1023, 17'h1FFFF, 17'h0FFFF));
      send_request(make_request(10'd256, 10'd0, 17'h10001, 17'h10001));

      top = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      bot = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      load_settings(top, bot, 32'h0000_FFFF, 32'hFFFF_FFFE);
      send_request(make_request(10'd0, 10'd0, 17'h10000, 17'h103FF));
      send_request(make_request(10'd1, 10'd1, 17'h103FF, 17'h0FFFF));
      send_request(make_request(10'd1023, 10'd1023, 17'h0FFFF, 17'h10000));
      send_request(make_request(10'd512, 10'd512, 17'h1FFFF, 17'h1FFFF));

      for (int p = 0; p < 16; p++) begin
         top = random_coefs($urandom_range(0, 2),
                            '{RST_TOP_COEF_A, RST_TOP_COEF_B, RST_TOP_COEF_C});
         bot = random_coefs($urandom_range(0, 2),
                            '{RST_BOT_COEF_A, RST_BOT_COEF_B, RST_BOT_COEF_C});
         case ($urandom_range(0, 4))
            0:       bmax_val = 16'd1;
            1:       bmax_val = 16'hFFFF;
            2:       bmax_val = 16'd0;
            default: bmax_val = 16'($urandom_range(256, 1024));
         endcase
         load_settings(top, bot, {16'($urandom()), bmax_val}, {31'($urandom()), 1'(p)});
         send_idle_pct = idle_modes[p % 4][0];
         stall_pct     = idle_modes[p % 4][1];
         if (p == 4) begin
            send_idle_pct = 0;
            hold_left     = 400;
            run_phase(120);
         end else if (p == 6) begin
            run_phase(36);
            wait_for_results();
            run_phase(36);
         end else begin
            run_phase(66);
         end
      end

      wait_for_results();
      repeat (60) @(posedge clock);
      if (duties.mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
